@@ design/nearest_palette_color_search_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define NPCS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("npcs: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define NPCS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("npcs: next-cycle check failed");

`endif

@@ design/npcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

    localparam int NPCS_DEPTH = 256;

    localparam int DIST_W = 18;
    localparam int BEST_W = 19;

    localparam logic [BEST_W-1:0] DIST_START = 19'h40000;
    localparam logic [7:0] GROUP_MASK = 8'h18;
    localparam logic [7:0] GROUP_LOW  = 8'h08;
    localparam logic [7:0] GROUP_HIGH = 8'h10;
    localparam logic [7:0] GROUP_STEP = 8'h08;
    localparam logic [7:0] NO_INDEX   = 8'hFF;
    localparam logic [3:0] MAX_BITS   = 4'd8;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic CFG_INDEX_BITS = 1'b0;
    localparam logic CFG_SWIZZLE    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } npcs_state_t;

    // Travels with each palette read through the distance pipeline.
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [7:0] idx;
    } npcs_tag_t;

endpackage

`default_nettype wire

@@ design/nearest_palette_color_search_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Load transaction: no result; busy stays low.
// Query transaction: N = min(2**index_bits, PALETTE_DEPTH) entries, one per cycle through
// the single palette read port; done strobes after the read and distance stages drain.
// No transaction is accepted while busy; the next is accepted at the edge ending done.
// Results cannot be stalled: done is high for exactly one cycle.
// Reset (rst_n low, async) clears control and config (index_bits 8, swizzle off), not palette.

module nearest_palette_color_search_unit #(
    parameter int PALETTE_DEPTH = npcs_pkg::NPCS_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    // command channel
    input  logic       start,
    output logic       busy,
    input  logic       req_type,
    input  logic [7:0] slot_addr,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    // result
    output logic       done,
    output logic [7:0] nearest_index,
    // config write port
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);

    import npcs_pkg::*;

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    npcs_state_t       state_reg, state_next;
    logic [7:0]        idx_reg, idx_next;
    logic [BEST_W-1:0] best_dist_reg, best_dist_next;
    logic [7:0]        best_idx_reg, best_idx_next;
    logic              done_reg, done_next;
    logic [7:0]        result_reg;
    logic [31:0]       color_reg;
    logic [3:0]        index_bits_reg;
    logic              swizzle_reg;
    npcs_tag_t         mem_tag_reg;

    logic              accept;
    logic              load_we;
    logic              finish;
    logic [3:0]        eff_bits;
    logic              swz_on;
    logic [8:0]        count;
    logic [8:0]        limit;
    logic [7:0]        start_idx;
    logic [7:0]        grp;
    logic [7:0]        phys;
    npcs_tag_t         issue_tag;
    logic [31:0]       rd_data;
    logic [DIST_W-1:0] dist_sum;
    npcs_tag_t         dist_tag;
    logic              dist_active;

    assign accept  = start && !busy;
    assign load_we = accept && (req_type == REQ_LOAD)
                     && ({1'b0, slot_addr} < 9'(PALETTE_DEPTH));

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg <= MAX_BITS;
            swizzle_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INDEX_BITS: index_bits_reg <= cfg_data;
                CFG_SWIZZLE:    swizzle_reg    <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // index widths above 8 behave as 8, swizzle test included
    assign eff_bits  = (index_bits_reg > MAX_BITS) ? MAX_BITS : index_bits_reg;
    assign swz_on    = swizzle_reg && (eff_bits == MAX_BITS);
    assign count     = 9'd1 << eff_bits;
    assign limit     = (count < 9'(PALETTE_DEPTH)) ? count : 9'(PALETTE_DEPTH);
    assign start_idx = 8'(limit - 9'd1);

    // ---- logical to physical slot ----
    // With swizzle on, groups 8-15 and 16-23 of each block of 32 trade places.
    assign grp = idx_reg & GROUP_MASK;

    always_comb
    begin
        phys = idx_reg;
        if (swz_on)
        begin
            if (grp == GROUP_LOW)
            begin
                phys = idx_reg + GROUP_STEP;
            end
            else if (grp == GROUP_HIGH)
            begin
                phys = idx_reg - GROUP_STEP;
            end
        end
    end

    assign issue_tag.valid = (state_reg == ST_SCAN);
    assign issue_tag.zero  = ({1'b0, phys} >= 9'(PALETTE_DEPTH));
    assign issue_tag.idx   = idx_reg;

    // ---- palette and distance pipeline ----
    npcs_palette_mem #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (load_we),
        .wr_addr (slot_addr[AW-1:0]),
        .wr_data ({alpha, blue, green, red}),
        .rd_addr (phys[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_tag_reg <= '0;
        end
        else
        begin
            mem_tag_reg <= issue_tag;
        end
    end

    npcs_dist_unit u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .entry   (rd_data),
        .color   (color_reg),
        .tag_in  (mem_tag_reg),
        .sum     (dist_sum),
        .tag_out (dist_tag),
        .active  (dist_active)
    );

    // ---- sequencer ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            best_dist_reg <= DIST_START;
            best_idx_reg  <= NO_INDEX;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
            done_reg      <= done_next;
        end
    end

    // query color and result are payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept && (req_type == REQ_QUERY))
        begin
            color_reg <= {alpha, blue, green, red};
        end
        if (finish)
        begin
            result_reg <= best_idx_reg;
        end
    end

    assign finish = (state_reg == ST_WAIT) && !mem_tag_reg.valid
                    && !dist_active && !dist_tag.valid;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        done_next      = 1'b0;

        // Strict less-than: scan runs downward, so ties keep the higher index.
        if (dist_tag.valid && ({1'b0, dist_sum} < best_dist_reg))
        begin
            best_dist_next = {1'b0, dist_sum};
            best_idx_next  = dist_tag.idx;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_QUERY))
                begin
                    state_next     = ST_SCAN;
                    idx_next       = start_idx;
                    best_dist_next = DIST_START;
                    best_idx_next  = NO_INDEX;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == 8'd0)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    idx_next = idx_reg - 8'd1;
                end
            end
            ST_WAIT:
            begin
                // drain the read and distance stages
                if (finish)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign nearest_index = result_reg;

endmodule

`default_nettype wire

@@ design/npcs_palette_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module npcs_palette_mem #(
    parameter int DEPTH = npcs_pkg::NPCS_DEPTH,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ design/npcs_dist_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module npcs_dist_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [31:0]               entry,
    input  logic [31:0]               color,
    input  npcs_pkg::npcs_tag_t       tag_in,
    output logic [npcs_pkg::DIST_W-1:0] sum,
    output npcs_pkg::npcs_tag_t       tag_out,
    output logic                      active
);

    import npcs_pkg::*;

    logic [15:0]       sq_reg [4];
    logic [DIST_W-1:0] sum_reg;
    npcs_tag_t         s1_tag_reg;
    npcs_tag_t         s2_tag_reg;
    logic [31:0]       ent;
    logic [7:0]        diff [4];

    // Out-of-range slot reads as zero.
    assign ent = tag_in.zero ? 32'd0 : entry;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (ent[8*c +: 8] > color[8*c +: 8])
            begin
                diff[c] = ent[8*c +: 8] - color[8*c +: 8];
            end
            else
            begin
                diff[c] = color[8*c +: 8] - ent[8*c +: 8];
            end
        end
    end

    // Stage 1: per-channel squares.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            sq_reg[c] <= diff[c] * diff[c];
        end
    end

    // Stage 2: four-way sum.
    always_ff @(posedge clk)
    begin
        sum_reg <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1])
                 + DIST_W'(sq_reg[2]) + DIST_W'(sq_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= tag_in;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    assign sum     = sum_reg;
    assign tag_out = s2_tag_reg;
    assign active  = s1_tag_reg.valid;

endmodule

`default_nettype wire

@@ design/npcs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_palette_color_search_unit_assert.svh"

module npcs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       req_type,
    input logic       done,
    input logic [7:0] nearest_index
);

    import npcs_pkg::*;

    logic query_acc;
    logic load_acc;

    assign query_acc = start && !busy && (req_type == REQ_QUERY);
    assign load_acc  = start && !busy && (req_type == REQ_LOAD);

    // a query transaction always occupies the unit
    `NPCS_ASSERT_NXT(a_query_busy, clk, rst_n, query_acc, busy)
    // a load transaction finishes at once and gives no result
    `NPCS_ASSERT_NXT(a_load_quiet, clk, rst_n, load_acc, !busy && !done)
    // result shows only once the unit is free again
    `NPCS_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy && !$isunknown(nearest_index))
    // end of a query always yields its result
    `NPCS_ASSERT_IMP(a_busy_fall, clk, rst_n, $fell(busy), done)
    // one strobe per query
    `NPCS_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)

endmodule

bind nearest_palette_color_search_unit npcs_checker u_npcs_checker (.*);

`default_nettype wire
